@@ rtl/cvtpc_pkg.sv @@
// ----------------------------------------------------------------------------
// cvtpc_pkg
// Shared types and constants for the cell versus tetrahedron plane classifier.
// ----------------------------------------------------------------------------
package cvtpc_pkg;

  // number of bounding planes of the clipping tetrahedron
  localparam int unsigned NUM_PLANES = 4;

  // plane register layout: three signed normals, then a signed offset
  localparam int unsigned NORM_W   = 11;
  localparam int unsigned OFFSET_W = 31;
  localparam int unsigned HEIGHT_W = 32;
  localparam int unsigned CFG_W    = 64;
  localparam int unsigned CFG_IDX_W = 3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PLANE_ZERO  = 3'd0,
    REG_PLANE_ONE   = 3'd1,
    REG_PLANE_TWO   = 3'd2,
    REG_PLANE_THREE = 3'd3,
    REG_HEIGHTS_LO  = 3'd4,
    REG_HEIGHTS_HI  = 3'd5
  } cfg_idx_t;

  // cell classification codes
  typedef enum logic [1:0] {
    CLS_OUT = 2'd0,
    CLS_ON  = 2'd1,
    CLS_IN  = 2'd2
  } label_t;

  // per-vertex plane test results handed to the cell accumulator
  typedef struct packed {
    logic [NUM_PLANES-1:0] below;  // d < 0
    logic [NUM_PLANES-1:0] above;  // d > height
    logic                  degen;
    logic                  last;
  } flags_t;

endpackage

@@ rtl/cell_vs_tet_plane_classifier_unit.sv @@
// ----------------------------------------------------------------------------
// cell_vs_tet_plane_classifier_unit
// Classifies a streamed mesh cell as out, on or in against a tetrahedron.
// ----------------------------------------------------------------------------
//
//  channel | dir | contents
//  --------+-----+---------------------------------------------------------
//  in_     | in  | one vertex per transfer; tuser degenerate, tlast last vertex
//  out_    | out | one cell label per transfer, after the last vertex
//  cfg_    | in  | register write: four planes, two height pairs
//
//  One vertex per cycle unless a stalled label holds the flow: the four plane
//  units (twelve multipliers) test a vertex combinationally. After the input
//  transfer of the last vertex the label passes the input, flag and label registers.
//  A stalled label holds in the result register; the next cell's vertices
//  keep flowing until its last vertex waits in the flag register, then one
//  more vertex fills the input register and the input stalls.
//  Synchronous reset clears pipeline valids, cell state and configuration registers.
//
module cell_vs_tet_plane_classifier_unit #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input vertex stream
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]    in_tdata,  // coord_x, coord_y, coord_z
  input  logic                                  in_tuser,  // degenerate
  input  logic                                  in_tlast,
  // output label stream
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [7:0]                            out_tdata, // label
  // configuration write port
  input  logic                                  cfg_we,
  input  logic [cvtpc_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  logic [cvtpc_pkg::CFG_W-1:0]           cfg_wdata
);

  localparam int unsigned NP = cvtpc_pkg::NUM_PLANES;
  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned HW = cvtpc_pkg::HEIGHT_W;

  // configuration registers
  logic [cvtpc_pkg::CFG_W-1:0] plane_r [NP];
  logic [cvtpc_pkg::CFG_W-1:0] heights_lo_r;
  logic [cvtpc_pkg::CFG_W-1:0] heights_hi_r;

  // pipeline registers
  logic                  s1_valid_r;
  logic signed [CW-1:0]  s1_x_r, s1_y_r, s1_z_r;
  logic                  s1_degen_r;
  logic                  s1_last_r;
  logic                  s2_valid_r;
  cvtpc_pkg::flags_t     s2_flags_r;
  cvtpc_pkg::flags_t     s1_flags;

  logic                  in_fire;
  logic                  s1_adv;
  logic                  s2_adv;
  logic                  out_free;
  logic signed [HW-1:0]  height [NP];
  cvtpc_pkg::label_t     out_label;

  // register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NP; i++) begin
        plane_r[i] <= '0;
      end
      heights_lo_r <= '0;
      heights_hi_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        cvtpc_pkg::REG_PLANE_ZERO:  plane_r[0]   <= cfg_wdata;
        cvtpc_pkg::REG_PLANE_ONE:   plane_r[1]   <= cfg_wdata;
        cvtpc_pkg::REG_PLANE_TWO:   plane_r[2]   <= cfg_wdata;
        cvtpc_pkg::REG_PLANE_THREE: plane_r[3]   <= cfg_wdata;
        cvtpc_pkg::REG_HEIGHTS_LO:  heights_lo_r <= cfg_wdata;
        cvtpc_pkg::REG_HEIGHTS_HI:  heights_hi_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign height[0] = $signed(heights_lo_r[HW-1:0]);
  assign height[1] = $signed(heights_lo_r[2*HW-1:HW]);
  assign height[2] = $signed(heights_hi_r[HW-1:0]);
  assign height[3] = $signed(heights_hi_r[2*HW-1:HW]);

  // pipeline flow control
  assign out_free  = !out_tvalid || out_tready;
  assign s2_adv    = s2_valid_r && (!s2_flags_r.last || out_free);
  assign s1_adv    = s1_valid_r && (!s2_valid_r || s2_adv);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;

  // stage 1: input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_x_r     <= $signed(in_tdata[CW-1:0]);
      s1_y_r     <= $signed(in_tdata[2*CW-1:CW]);
      s1_z_r     <= $signed(in_tdata[3*CW-1:2*CW]);
      s1_degen_r <= in_tuser;
      s1_last_r  <= in_tlast;
    end
  end

  // plane distance units
  for (genvar p = 0; p < NP; p++) begin : g_plane
    cvtpc_plane_eval #(
      .COORD_WIDTH (CW)
    ) u_plane_eval (
      .vx     (s1_x_r),
      .vy     (s1_y_r),
      .vz     (s1_z_r),
      .plane  (plane_r[p]),
      .height (height[p]),
      .below  (s1_flags.below[p]),
      .above  (s1_flags.above[p])
    );
  end

  assign s1_flags.degen = s1_degen_r;
  assign s1_flags.last  = s1_last_r;

  // stage 2: flag register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s2_valid_r <= 1'b1;
    end else if (s2_adv) begin
      s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_flags_r <= s1_flags;
    end
  end

  // stage 3: cell accumulation and label register
  cvtpc_cell_accum u_cell_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (s2_adv),
    .flags      (s2_flags_r),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_label  (out_label)
  );

  assign out_tdata = {6'b0, out_label};

endmodule

@@ rtl/cvtpc_plane_eval.sv @@
// ----------------------------------------------------------------------------
// cvtpc_plane_eval
// Signed distance of one vertex to one plane, tested against zero and the
// apex height of that plane.
// ----------------------------------------------------------------------------
module cvtpc_plane_eval #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic signed [COORD_WIDTH-1:0]            vx,
  input  logic signed [COORD_WIDTH-1:0]            vy,
  input  logic signed [COORD_WIDTH-1:0]            vz,
  input  logic        [cvtpc_pkg::CFG_W-1:0]       plane,
  input  logic signed [cvtpc_pkg::HEIGHT_W-1:0]    height,
  output logic                                     below,
  output logic                                     above
);

  // product width and distance width, wide enough to stay exact
  localparam int unsigned PW  = COORD_WIDTH + cvtpc_pkg::NORM_W;
  localparam int unsigned SW  = PW + 3;
  localparam int unsigned DW  = (SW > cvtpc_pkg::HEIGHT_W + 1) ? SW
                                                              : cvtpc_pkg::HEIGHT_W + 1;
  localparam int unsigned NW  = cvtpc_pkg::NORM_W;

  logic signed [NW-1:0]                   nx, ny, nz;
  logic signed [cvtpc_pkg::OFFSET_W-1:0]  offset;
  logic signed [PW-1:0]                   px, py, pz;
  logic signed [DW-1:0]                   distance;

  // unpack the plane register
  assign nx     = $signed(plane[NW-1:0]);
  assign ny     = $signed(plane[2*NW-1:NW]);
  assign nz     = $signed(plane[3*NW-1:2*NW]);
  assign offset = $signed(plane[cvtpc_pkg::CFG_W-1:3*NW]);

  // one multiplier per normal component
  assign px = PW'(nx) * PW'(vx);
  assign py = PW'(ny) * PW'(vy);
  assign pz = PW'(nz) * PW'(vz);

  // d = n . v - offset
  assign distance = DW'(px) + DW'(py) + DW'(pz) - DW'(offset);

  // side tests
  assign below = distance[DW-1];
  assign above = distance > DW'(height);

endmodule

@@ rtl/cvtpc_cell_accum.sv @@
// ----------------------------------------------------------------------------
// cvtpc_cell_accum
// Folds per-vertex plane flags over one cell and registers the cell label.
// ----------------------------------------------------------------------------
module cvtpc_cell_accum (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      fire,
  input  cvtpc_pkg::flags_t         flags,
  input  logic                      out_tready,
  output logic                      out_tvalid,
  output cvtpc_pkg::label_t         out_label
);

  localparam int unsigned NP = cvtpc_pkg::NUM_PLANES;

  logic [NP-1:0]      all_below_r, all_below_nxt;
  logic [NP-1:0]      all_above_r, all_above_nxt;
  logic               inside_r, inside_nxt;
  logic               degen_r, degen_nxt;
  logic               out_valid_r;
  cvtpc_pkg::label_t  label_r, label_nxt;

  // cell state including the current vertex
  always_comb begin
    all_below_nxt = all_below_r & flags.below;
    all_above_nxt = all_above_r & flags.above;
    inside_nxt    = inside_r & ~(|flags.below);
    degen_nxt     = degen_r | flags.degen;
    priority if (degen_nxt || (|all_below_nxt) || (|all_above_nxt)) begin
      label_nxt = cvtpc_pkg::CLS_OUT;
    end else if (inside_nxt) begin
      label_nxt = cvtpc_pkg::CLS_IN;
    end else begin
      label_nxt = cvtpc_pkg::CLS_ON;
    end
  end

  // accumulate, clear at the end of a cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      all_below_r <= '1;
      all_above_r <= '1;
      inside_r    <= 1'b1;
      degen_r     <= 1'b0;
    end else if (fire) begin
      if (flags.last) begin
        all_below_r <= '1;
        all_above_r <= '1;
        inside_r    <= 1'b1;
        degen_r     <= 1'b0;
      end else begin
        all_below_r <= all_below_nxt;
        all_above_r <= all_above_nxt;
        inside_r    <= inside_nxt;
        degen_r     <= degen_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && flags.last) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && flags.last) begin
      label_r <= label_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_label  = label_r;

endmodule

@@ rtl/cvtpc_checker.sv @@
// ----------------------------------------------------------------------------
// cvtpc_checker
// Port-level checks on the label stream of the classifier.
// ----------------------------------------------------------------------------
module cvtpc_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata
);

  // a pending label is not dropped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("label dropped while stalled");

  // a pending label keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("label changed while stalled");

  // only the three defined codes appear, padding stays zero
  a_label_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7:2] == '0) &&
                   (out_tdata[1:0] == cvtpc_pkg::CLS_OUT ||
                    out_tdata[1:0] == cvtpc_pkg::CLS_ON  ||
                    out_tdata[1:0] == cvtpc_pkg::CLS_IN))
    else $error("undefined label code");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("label valid after reset");

endmodule

bind cell_vs_tet_plane_classifier_unit cvtpc_checker u_cvtpc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
